### rtl/hmmd_pkg.sv
// Shared types, constants and address decode functions of the handheld memory map decoder.
`timescale 1ns / 1ps
`default_nettype none

package hmmd_pkg;

    // Store sizes
    localparam int C_CART_BYTES = 32768;
    localparam int C_BOOT_BYTES = 256;
    localparam int C_VRAM_BYTES = 8192;
    localparam int C_WRAM_BYTES = 8192;
    localparam int C_IO_BYTES   = 128;
    localparam int C_HRAM_BYTES = 127;

    localparam int C_CART_AW = $clog2(C_CART_BYTES);
    localparam int C_BOOT_AW = $clog2(C_BOOT_BYTES);
    localparam int C_IDX_W   = C_CART_AW;             // widest store index
    localparam int C_CLR_W   = $clog2(C_VRAM_BYTES);  // clearing sweep counter

    // Fixed addresses and values
    localparam logic [15:0] C_LY_ADDR       = 16'hFF44;
    localparam logic [7:0]  C_LY_VALUE      = 8'h90;
    localparam logic [15:0] C_BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [15:0] C_SC_ADDR       = 16'hFF02;
    localparam logic [7:0]  C_SC_START      = 8'h81;
    localparam logic [C_IDX_W-1:0] C_SB_INDEX = C_IDX_W'(1);

    // Bus operations carried in the request kind
    typedef enum logic [2:0] {
        OP_RD_BYTE = 3'd0,
        OP_RD_WORD = 3'd1,
        OP_WR_BYTE = 3'd2,
        OP_WR_WORD = 3'd3,
        OP_LD_CART = 3'd4,
        OP_LD_BOOT = 3'd5
    } t_op;

    // Where a byte access lands
    typedef enum logic [2:0] {
        REG_NONE,
        REG_BOOT,
        REG_CART,
        REG_VRAM,
        REG_WRAM,
        REG_IO,
        REG_HRAM,
        REG_FIXED
    } t_region;

    typedef struct packed {
        t_region              region;
        logic [C_IDX_W-1:0]   idx;
    } t_target;

    // One access to a byte store
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [C_IDX_W-1:0]   addr;
        logic [7:0]           wdata;
    } t_mem_req;

    // Read map
    function automatic t_target f_read_decode(input logic [15:0] a, input logic ovl);
        t_target t;
        t.region = REG_NONE;
        t.idx    = '0;
        if ((a < 16'(C_BOOT_BYTES)) && ovl) begin
            t.region = REG_BOOT;
            t.idx    = C_IDX_W'(a[C_BOOT_AW-1:0]);
        end else if (a < 16'h8000) begin
            t.region = REG_CART;
            t.idx    = a[C_CART_AW-1:0];
        end else if (a inside {[16'h8000:16'h9FFF]}) begin
            t.region = REG_VRAM;
            t.idx    = C_IDX_W'(a[12:0]);
        end else if (a inside {[16'hC000:16'hFDFF]}) begin
            // echo folds onto the same 8 KiB
            t.region = REG_WRAM;
            t.idx    = C_IDX_W'(a[12:0]);
        end else if (a inside {[16'hFF00:16'hFF7F]}) begin
            t.region = (a == C_LY_ADDR) ? REG_FIXED : REG_IO;
            t.idx    = C_IDX_W'(a[6:0]);
        end else if (a inside {[16'hFF80:16'hFFFE]}) begin
            t.region = REG_HRAM;
            t.idx    = C_IDX_W'(a[6:0]);
        end
        return t;
    endfunction

    // Write map: ROM and holes are dropped
    function automatic t_target f_write_decode(input logic [15:0] a);
        t_target t;
        t.region = REG_NONE;
        t.idx    = C_IDX_W'(a[12:0]);
        if (a inside {[16'h8000:16'h9FFF]}) begin
            t.region = REG_VRAM;
        end else if (a inside {[16'hC000:16'hFDFF]}) begin
            t.region = REG_WRAM;
        end else if (a inside {[16'hFF00:16'hFF7F]}) begin
            t.region = REG_IO;
            t.idx    = C_IDX_W'(a[6:0]);
        end else if (a inside {[16'hFF80:16'hFFFE]}) begin
            t.region = REG_HRAM;
            t.idx    = C_IDX_W'(a[6:0]);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/hmmd_ram.sv
// Single-port byte store with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hmmd_ram
    import hmmd_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic       i_clk,
    input  wire t_mem_req   i_req,
    output logic [7:0]      o_rdata
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] w_idx;
    logic          w_in_range;

    assign w_idx      = i_req.addr[AW-1:0];
    assign w_in_range = {1'b0, w_idx} < (AW + 1)'(DEPTH);

    // One access per cycle: write wins, otherwise read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            if (w_in_range) begin
                r_mem[w_idx] <= i_req.wdata;
            end
        end else if (i_req.re) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/hmmd_seq.sv
// Access sequencer: clearing sweep, per-byte store accesses, result register.
`timescale 1ns / 1ps
`default_nettype none

module hmmd_seq
    import hmmd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request side
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    input  wire logic [2:0]    i_op,
    input  wire logic [15:0]   i_addr,
    input  wire logic [15:0]   i_data,
    // result side
    output logic               o_m_valid,
    input  wire logic          i_m_ready,
    output logic [15:0]        o_read_data,
    output logic               o_serial_valid,
    output logic [7:0]         o_serial_byte,
    // overlay register
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_data,
    // store ports
    output t_mem_req           o_req_cart,
    output t_mem_req           o_req_boot,
    output t_mem_req           o_req_vram,
    output t_mem_req           o_req_wram,
    output t_mem_req           o_req_io,
    output t_mem_req           o_req_hram,
    input  wire logic [7:0]    i_rd_cart,
    input  wire logic [7:0]    i_rd_boot,
    input  wire logic [7:0]    i_rd_vram,
    input  wire logic [7:0]    i_rd_wram,
    input  wire logic [7:0]    i_rd_io,
    input  wire logic [7:0]    i_rd_hram
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WORD,
        S_FIN
    } t_state;

    localparam logic [C_CLR_W-1:0] C_CLR_LAST = '1;

    t_state               r_state, n_state;
    logic [C_CLR_W-1:0]   r_clr_cnt;
    logic                 r_overlay;
    t_op                  r_op;
    logic [15:0]          r_addr;
    logic [15:0]          r_data;
    t_region              r_src;
    logic                 r_emit;
    logic                 r_emit0;
    logic [7:0]           r_lo;
    logic                 r_m_valid;
    logic [15:0]          r_m_rd;
    logic                 r_m_sv;
    logic [7:0]           r_m_sb;

    logic                 w_accept;
    logic                 w_iss;
    t_op                  w_iss_op;
    logic [15:0]          w_iss_addr;
    logic [7:0]           w_iss_byte;
    t_target              w_rtgt, w_wtgt, w_tgt;
    logic                 w_we, w_re, w_emit, w_ovl_clr;
    t_region              w_src;
    logic [7:0]           w_byte;
    logic                 w_load;
    logic [15:0]          w_rd;
    logic                 w_sv;
    logic [7:0]           w_sb;
    logic                 w_mem_busy;

    assign o_s_ready = (r_state == S_IDLE);
    assign w_accept  = o_s_ready && i_s_valid;
    assign w_load    = (r_state == S_FIN) && (!r_m_valid || i_m_ready);

    // Byte step to issue: low byte on accept, high byte in the cycle after it (S_WORD)
    always_comb begin
        w_iss      = 1'b0;
        w_iss_op   = OP_RD_BYTE;
        w_iss_addr = '0;
        w_iss_byte = '0;
        if (w_accept) begin
            w_iss      = 1'b1;
            w_iss_op   = t_op'(i_op);
            w_iss_addr = i_addr;
            w_iss_byte = i_data[7:0];
        end else if (r_state == S_WORD) begin
            w_iss      = 1'b1;
            w_iss_op   = r_op;
            w_iss_addr = r_addr + 16'd1;
            w_iss_byte = r_data[15:8];
        end
    end

    // Decode the byte step into one store access
    always_comb begin
        w_rtgt    = f_read_decode(w_iss_addr, r_overlay);
        w_wtgt    = f_write_decode(w_iss_addr);
        w_tgt     = '{region: REG_NONE, idx: '0};
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_emit    = 1'b0;
        w_ovl_clr = 1'b0;
        w_src     = REG_NONE;
        if (w_iss) begin
            case (w_iss_op)
                OP_RD_BYTE, OP_RD_WORD: begin
                    w_tgt = w_rtgt;
                    w_re  = 1'b1;
                    w_src = w_rtgt.region;
                end
                OP_WR_BYTE, OP_WR_WORD: begin
                    if (w_iss_addr == C_BOOT_OFF_ADDR) begin
                        w_ovl_clr = 1'b1;
                    end else if (w_iss_addr == C_SC_ADDR && w_iss_byte == C_SC_START) begin
                        // transfer start: fetch the serial data byte instead of storing
                        w_emit = 1'b1;
                        w_re   = 1'b1;
                        w_tgt  = '{region: REG_IO, idx: C_SB_INDEX};
                        w_src  = REG_IO;
                    end else begin
                        w_tgt = w_wtgt;
                        w_we  = 1'b1;
                    end
                end
                OP_LD_CART: begin
                    w_tgt = '{region: REG_CART, idx: w_iss_addr[C_CART_AW-1:0]};
                    w_we  = 1'b1;
                end
                OP_LD_BOOT: begin
                    w_tgt = '{region: REG_BOOT, idx: C_IDX_W'(w_iss_addr[C_BOOT_AW-1:0])};
                    w_we  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Store ports; the sweep zeroes the cleared stores after reset
    always_comb begin
        o_req_cart = '{we: w_we && w_tgt.region == REG_CART,
                       re: w_re && w_tgt.region == REG_CART,
                       addr: w_tgt.idx, wdata: w_iss_byte};
        o_req_boot = '{we: w_we && w_tgt.region == REG_BOOT,
                       re: w_re && w_tgt.region == REG_BOOT,
                       addr: w_tgt.idx, wdata: w_iss_byte};
        o_req_vram = '{we: w_we && w_tgt.region == REG_VRAM,
                       re: w_re && w_tgt.region == REG_VRAM,
                       addr: w_tgt.idx, wdata: w_iss_byte};
        o_req_wram = '{we: w_we && w_tgt.region == REG_WRAM,
                       re: w_re && w_tgt.region == REG_WRAM,
                       addr: w_tgt.idx, wdata: w_iss_byte};
        o_req_io   = '{we: w_we && w_tgt.region == REG_IO,
                       re: w_re && w_tgt.region == REG_IO,
                       addr: w_tgt.idx, wdata: w_iss_byte};
        o_req_hram = '{we: w_we && w_tgt.region == REG_HRAM,
                       re: w_re && w_tgt.region == REG_HRAM,
                       addr: w_tgt.idx, wdata: w_iss_byte};
        if (r_state == S_CLEAR) begin
            o_req_vram = '{we: 1'b1, re: 1'b0, addr: C_IDX_W'(r_clr_cnt), wdata: 8'h00};
            o_req_wram = '{we: 1'b1, re: 1'b0, addr: C_IDX_W'(r_clr_cnt), wdata: 8'h00};
            o_req_io   = '{we: 1'b1, re: 1'b0, addr: C_IDX_W'(r_clr_cnt), wdata: 8'h00};
            o_req_hram = '{we: 1'b1, re: 1'b0, addr: C_IDX_W'(r_clr_cnt), wdata: 8'h00};
        end
    end

    assign w_mem_busy = o_req_cart.we | o_req_cart.re | o_req_boot.we | o_req_boot.re
                      | o_req_vram.we | o_req_vram.re | o_req_wram.we | o_req_wram.re
                      | o_req_io.we   | o_req_io.re   | o_req_hram.we | o_req_hram.re;

    // Byte returned by the previous step
    always_comb begin
        case (r_src)
            REG_BOOT:  w_byte = i_rd_boot;
            REG_CART:  w_byte = i_rd_cart;
            REG_VRAM:  w_byte = i_rd_vram;
            REG_WRAM:  w_byte = i_rd_wram;
            REG_IO:    w_byte = i_rd_io;
            REG_HRAM:  w_byte = i_rd_hram;
            REG_FIXED: w_byte = C_LY_VALUE;
            default:   w_byte = 8'h00;
        endcase
    end

    // Result fields
    always_comb begin
        w_rd = '0;
        w_sv = 1'b0;
        w_sb = '0;
        case (r_op)
            OP_RD_BYTE: w_rd = {8'h00, w_byte};
            OP_RD_WORD: w_rd = {w_byte, r_lo};
            OP_WR_BYTE, OP_WR_WORD: begin
                w_sv = r_emit | r_emit0;
                if (r_emit) begin
                    w_sb = w_byte;
                end else if (r_emit0) begin
                    w_sb = r_lo;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_cnt == C_CLR_LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_op) == OP_RD_WORD || t_op'(i_op) == OP_WR_WORD)
                            ? S_WORD : S_FIN;
                end
            end
            S_WORD:  n_state = S_FIN;
            S_FIN:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State, captured bytes and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_overlay <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_valid) begin
                r_overlay <= i_cfg_data;
            end else if (w_ovl_clr) begin
                r_overlay <= 1'b0;
            end
            if (w_accept) begin
                r_op    <= t_op'(i_op);
                r_addr  <= i_addr;
                r_data  <= i_data;
                r_emit0 <= 1'b0;
            end
            if (r_state == S_WORD) begin
                r_lo    <= w_byte;
                r_emit0 <= r_emit;
            end
            if (w_iss) begin
                r_src  <= w_src;
                r_emit <= w_emit;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
                r_m_rd    <= w_rd;
                r_m_sv    <= w_sv;
                r_m_sb    <= w_sb;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid      = r_m_valid;
    assign o_read_data    = r_m_rd;
    assign o_serial_valid = r_m_sv;
    assign o_serial_byte  = r_m_sb;

    // An accepted request always moves on to a byte step or the result stage
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_WORD || r_state == S_FIN))
        else $error("accepted request did not advance");

    // The result stage issues no store access, so read data holds while stalled
    a_fin_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !w_mem_busy)
        else $error("store access during result stage");

    // An emitted serial byte only comes with a zero read field
    a_serial_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_sv) |-> (r_m_rd == 16'h0000))
        else $error("serial emit with nonzero read data");

    // A word write emits at most once
    a_single_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !(r_emit && r_emit0))
        else $error("two serial emissions in one request");

    // The sweep counter moves only while clearing
    a_clr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> $stable(r_clr_cnt))
        else $error("clear counter moved outside clearing");

endmodule

`default_nettype wire

### rtl/handheld_memory_map_decoder.sv
// Top level of the handheld memory map decoder: sequencer and byte stores.
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tuser: operation; tdata: address, data
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tuser: serial_valid; tdata: read_data,
//                                                    serial_byte
//  cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_data: boot overlay flag
//
// Every byte is one access on a single-ported store with a registered read: byte operations
// and loads take one byte step, word operations add one for the high byte, then a result stage.
// After reset a clearing sweep zeroes video, work, IO and high RAM;
// requests are held off meanwhile, configuration writes are taken at any time.
// A stalled result holds the block in its result stage; a new request is taken as soon
// as the result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module handheld_memory_map_decoder
    import hmmd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [31:0]   i_s_axis_tdata,   // [15:0] address, [31:16] data
    input  wire logic [2:0]    i_s_axis_tuser,   // [2:0] operation
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,   // [15:0] read_data, [23:16] serial_byte
    output logic               o_m_axis_tuser,   // [0] serial_valid
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_data
);

    t_mem_req   w_req_cart, w_req_boot, w_req_vram, w_req_wram, w_req_io, w_req_hram;
    logic [7:0] w_rd_cart, w_rd_boot, w_rd_vram, w_rd_wram, w_rd_io, w_rd_hram;
    logic [15:0] w_read_data;
    logic [7:0]  w_serial_byte;

    assign o_cfg_ready = 1'b1;

    hmmd_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (i_s_axis_tvalid),
        .o_s_ready      (o_s_axis_tready),
        .i_op           (i_s_axis_tuser),
        .i_addr         (i_s_axis_tdata[15:0]),
        .i_data         (i_s_axis_tdata[31:16]),
        .o_m_valid      (o_m_axis_tvalid),
        .i_m_ready      (i_m_axis_tready),
        .o_read_data    (w_read_data),
        .o_serial_valid (o_m_axis_tuser),
        .o_serial_byte  (w_serial_byte),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_req_cart     (w_req_cart),
        .o_req_boot     (w_req_boot),
        .o_req_vram     (w_req_vram),
        .o_req_wram     (w_req_wram),
        .o_req_io       (w_req_io),
        .o_req_hram     (w_req_hram),
        .i_rd_cart      (w_rd_cart),
        .i_rd_boot      (w_rd_boot),
        .i_rd_vram      (w_rd_vram),
        .i_rd_wram      (w_rd_wram),
        .i_rd_io        (w_rd_io),
        .i_rd_hram      (w_rd_hram)
    );

    assign o_m_axis_tdata = {w_serial_byte, w_read_data};

    // Byte stores
    hmmd_ram #(.DEPTH(C_CART_BYTES)) u_cart (
        .i_clk(i_clk), .i_req(w_req_cart), .o_rdata(w_rd_cart));
    hmmd_ram #(.DEPTH(C_BOOT_BYTES)) u_boot (
        .i_clk(i_clk), .i_req(w_req_boot), .o_rdata(w_rd_boot));
    hmmd_ram #(.DEPTH(C_VRAM_BYTES)) u_vram (
        .i_clk(i_clk), .i_req(w_req_vram), .o_rdata(w_rd_vram));
    hmmd_ram #(.DEPTH(C_WRAM_BYTES)) u_wram (
        .i_clk(i_clk), .i_req(w_req_wram), .o_rdata(w_rd_wram));
    hmmd_ram #(.DEPTH(C_IO_BYTES)) u_io (
        .i_clk(i_clk), .i_req(w_req_io), .o_rdata(w_rd_io));
    hmmd_ram #(.DEPTH(C_HRAM_BYTES)) u_hram (
        .i_clk(i_clk), .i_req(w_req_hram), .o_rdata(w_rd_hram));

endmodule

`default_nettype wire

### sim/handheld_memory_map_decoder_tb.sv
// Self-checking testbench for the handheld memory map decoder: directed and random bus requests.
`timescale 1ns / 1ps

module handheld_memory_map_decoder_tb;
    import hmmd_pkg::*;

    // Fixed addresses and values of the memory map
    localparam logic [15:0] ADDR_SB       = 16'hFF01;
    localparam logic [15:0] ADDR_SC       = 16'hFF02;
    localparam logic [15:0] ADDR_LY       = 16'hFF44;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [7:0]  LY_READ       = 8'h90;
    localparam logic [7:0]  SC_START      = 8'h81;

    // Operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [15:0] data;
    } t_bus_req;

    typedef struct {
        logic [15:0] read_data;
        logic        serial_valid;
        logic [7:0]  serial_byte;
    } t_bus_resp;

    // Block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;    // [15:0] address, [31:16] data
    logic [2:0]  i_s_axis_tuser = '0;    // [2:0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;         // [15:0] read_data, [23:16] serial_byte
    logic        o_m_axis_tuser;         // [0] serial_valid
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    handheld_memory_map_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the memory map, updated as requests are accepted
    bit [7:0] cart_shadow [32768];
    bit [7:0] boot_shadow [256];
    bit [7:0] vram_shadow [8192];
    bit [7:0] wram_shadow [8192];
    bit [7:0] io_shadow   [128];
    bit [7:0] hram_shadow [127];
    bit       overlay_shadow = 1'b0;
    bit       overlay_cfg = 1'b0;

    // Stimulus side view: which ROM bytes are loaded and where the overlay will stand
    bit          cart_loaded [32768];
    bit          boot_loaded [256];
    bit          gen_overlay = 1'b0;
    logic [15:0] touched_q [$];

    t_bus_req    pending_q [$];
    t_bus_resp   expected_q [$];
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          req_taken = 1'b0;

    // One byte read through the address map
    function automatic logic [7:0] map_read(input logic [15:0] a);
        if (a < 16'h0100 && overlay_shadow) return boot_shadow[a[7:0]];
        if (a < 16'h8000) return cart_shadow[a[14:0]];
        if (a <= 16'h9FFF) return vram_shadow[a[12:0]];
        if (a >= 16'hC000 && a <= 16'hFDFF) return wram_shadow[a[12:0]];
        if (a >= 16'hFF00 && a <= 16'hFF7F) begin
            if (a == ADDR_LY) return LY_READ;
            return io_shadow[a[6:0]];
        end
        if (a >= 16'hFF80 && a <= 16'hFFFE) return hram_shadow[a[6:0]];
        return 8'h00;
    endfunction

    // One byte write; returns 1 when a serial transfer start sends the data byte
    function automatic bit map_write(input logic [15:0] a, input logic [7:0] d,
                                     output logic [7:0] ser);
        ser = 8'h00;
        if (a >= 16'h8000 && a <= 16'h9FFF) begin
            vram_shadow[a[12:0]] = d;
        end else if (a >= 16'hC000 && a <= 16'hFDFF) begin
            wram_shadow[a[12:0]] = d;
        end else if (a >= 16'hFF00 && a <= 16'hFF7F) begin
            if (a == ADDR_BOOT_OFF) begin
                overlay_shadow = 1'b0;
            end else if (a == ADDR_SC && d == SC_START) begin
                ser = io_shadow[1];
                return 1'b1;
            end else begin
                io_shadow[a[6:0]] = d;
            end
        end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
            hram_shadow[a[6:0]] = d;
        end
        return 1'b0;
    endfunction

    // Result of one bus request, applied to the shadow copy
    function automatic t_bus_resp bus_response(input logic [2:0] op, input logic [15:0] a,
                                               input logic [15:0] d);
        t_bus_resp r;
        logic [7:0] s_lo, s_hi;
        bit e_lo, e_hi;
        r = '{16'h0000, 1'b0, 8'h00};
        case (op)
            OP_RD_BYTE: r.read_data = {8'h00, map_read(a)};
            OP_RD_WORD: r.read_data = {map_read(a + 16'd1), map_read(a)};
            OP_WR_BYTE: begin
                r.serial_valid = map_write(a, d[7:0], s_lo);
                r.serial_byte  = s_lo;
            end
            OP_WR_WORD: begin
                e_lo = map_write(a, d[7:0], s_lo);
                e_hi = map_write(a + 16'd1, d[15:8], s_hi);
                r.serial_valid = e_lo | e_hi;
                r.serial_byte  = e_lo ? s_lo : (e_hi ? s_hi : 8'h00);
            end
            OP_LD_CART: cart_shadow[a[14:0]] = d[7:0];
            OP_LD_BOOT: boot_shadow[a[7:0]] = d[7:0];
            default: ;
        endcase
        return r;
    endfunction

    // Idle length: mostly short, a few long, none at all in quiet stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (((cycles / 2000) % 4) == 1) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Queue one request and track its effect on loaded ROM bytes and the overlay
    function automatic void push_req(input logic [2:0] op, input logic [15:0] a,
                                     input logic [15:0] d);
        if (op == OP_LD_CART) cart_loaded[a[14:0]] = 1'b1;
        if (op == OP_LD_BOOT) boot_loaded[a[7:0]] = 1'b1;
        if ((op == OP_WR_BYTE || op == OP_WR_WORD) && a == ADDR_BOOT_OFF) gen_overlay = 1'b0;
        if (op == OP_WR_WORD && a + 16'd1 == ADDR_BOOT_OFF) gen_overlay = 1'b0;
        if (op != OP_SPARE_A && op != OP_SPARE_B && op != OP_RD_BYTE && op != OP_RD_WORD) begin
            touched_q.push_back((op == OP_LD_CART) ? {1'b0, a[14:0]} :
                                (op == OP_LD_BOOT) ? {8'h00, a[7:0]} : a);
            if (touched_q.size() > 32) void'(touched_q.pop_front());
        end
        pending_q.push_back('{op, a, d});
    endfunction

    // A read of a ROM byte never loaded is preceded by a load of it
    function automatic void queue_request(input logic [2:0] op, input logic [15:0] a,
                                          input logic [15:0] d);
        logic [15:0] b;
        int n;
        n = (op == OP_RD_WORD) ? 2 : ((op == OP_RD_BYTE) ? 1 : 0);
        for (int k = 0; k < n; k++) begin
            b = a + 16'(k);
            if (b < 16'h0100 && gen_overlay) begin
                if (!boot_loaded[b[7:0]]) push_req(OP_LD_BOOT, b, 16'($urandom));
            end else if (b < 16'h8000) begin
                if (!cart_loaded[b[14:0]]) push_req(OP_LD_CART, b, 16'($urandom));
            end
        end
        push_req(op, a, d);
    endfunction

    function automatic logic [15:0] pick_addr();
        logic [15:0] hot [12];
        hot = '{ADDR_SB, ADDR_SC, ADDR_LY, ADDR_BOOT_OFF, 16'hFF4F, 16'hFF7F,
                16'hFF80, 16'hFFFE, 16'hFFFF, 16'h00FF, 16'h7FFF, 16'h9FFF};
        case ($urandom_range(0, 11))
            0: return 16'($urandom_range(16'h0000, 16'h00FF));
            1: return 16'($urandom_range(16'h0100, 16'h7FFF));
            2: return 16'($urandom_range(16'h8000, 16'h9FFF));
            3: return 16'($urandom_range(16'hA000, 16'hBFFF));
            4: return 16'($urandom_range(16'hC000, 16'hDFFF));
            5: return 16'($urandom_range(16'hE000, 16'hFDFF));
            6: return 16'($urandom_range(16'hFE00, 16'hFEFF));
            7: return 16'($urandom_range(16'hFF00, 16'hFF7F));
            8: return hot[$urandom_range(0, 11)];
            9: return 16'($urandom_range(16'hFF80, 16'hFFFF));
            default: begin
                if (touched_q.size() == 0) return 16'($urandom);
                return touched_q[$urandom_range(0, touched_q.size() - 1)];
            end
        endcase
    endfunction

    // Random requests, weighted toward reads and writes of live addresses
    function automatic void queue_random(input int count);
        int unsigned r;
        logic [2:0]  op;
        logic [15:0] a, d;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 22)      op = OP_RD_BYTE;
            else if (r < 40) op = OP_RD_WORD;
            else if (r < 62) op = OP_WR_BYTE;
            else if (r < 78) op = OP_WR_WORD;
            else if (r < 86) op = OP_LD_CART;
            else if (r < 92) op = OP_LD_BOOT;
            else if (r < 96) op = OP_SPARE_A;
            else             op = OP_SPARE_B;
            a = (op == OP_LD_CART || op == OP_LD_BOOT) ? 16'($urandom) : pick_addr();
            d = 16'($urandom);
            if (a == ADDR_SC && $urandom_range(0, 1)) d[7:0] = SC_START;
            if (op == OP_WR_WORD && a == ADDR_SB && $urandom_range(0, 1)) d[15:8] = SC_START;
            queue_request(op, a, d);
        end
    endfunction

    // Overlay register write, only while no request is in flight
    task automatic write_overlay_cfg(input logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        overlay_cfg    = v;
        overlay_shadow = overlay_cfg;
        gen_overlay    = overlay_cfg;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every expected result is back
    task automatic wait_drained();
        while (pending_q.size() != 0 || i_s_axis_tvalid || expected_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Request driver
    always @(negedge i_clk) begin
        t_bus_req nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || req_taken) begin
            if (send_gap > 0) begin
                send_gap        <= send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                nxt = pending_q.pop_front();
                i_s_axis_tdata  <= {nxt.data, nxt.addr};
                i_s_axis_tuser  <= nxt.op;
                i_s_axis_tvalid <= 1'b1;
                send_gap        <= pick_gap();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // Prediction on accepted requests, checking of accepted results, run limit
    always @(posedge i_clk) begin
        t_bus_resp want;
        cycles    <= cycles + 1;
        req_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (req_taken)
            expected_q.push_back(bus_response(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                              i_s_axis_tdata[31:16]));
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: read_data %h serial_valid %b serial_byte %h",
                       o_m_axis_tdata[15:0], o_m_axis_tuser, o_m_axis_tdata[23:16]);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_m_axis_tdata[15:0] !== want.read_data) begin
                    $error("read_data: expected %h, actual %h", want.read_data,
                           o_m_axis_tdata[15:0]);
                    errors++;
                end
                if (o_m_axis_tuser !== want.serial_valid) begin
                    $error("serial_valid: expected %b, actual %b", want.serial_valid,
                           o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[23:16] !== want.serial_byte) begin
                    $error("serial_byte: expected %h, actual %h", want.serial_byte,
                           o_m_axis_tdata[23:16]);
                    errors++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("handheld_memory_map_decoder test failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass with the boot overlay on
        write_overlay_cfg(1'b1);
        queue_request(OP_LD_BOOT, 16'hFF00, 16'h003C);     // offset wraps to 0
        queue_request(OP_LD_BOOT, 16'h00FF, 16'hFFFF);
        queue_request(OP_LD_CART, 16'h0000, 16'h0000);
        queue_request(OP_LD_CART, 16'hFFFF, 16'h005A);     // offset wraps to 0x7FFF
        queue_request(OP_RD_BYTE, 16'h0000, 16'h0000);
        queue_request(OP_RD_WORD, 16'h00FF, 16'h0000);     // boot byte then cart byte
        queue_request(OP_WR_WORD, 16'h8000, 16'hFFFF);
        queue_request(OP_RD_WORD, 16'h9FFF, 16'h0000);     // video end and unmapped hole
        queue_request(OP_WR_BYTE, 16'hC000, 16'h0012);
        queue_request(OP_RD_BYTE, 16'hE000, 16'h0000);     // echo of work RAM
        queue_request(OP_WR_BYTE, 16'hFDFF, 16'h00A5);
        queue_request(OP_RD_WORD, 16'hDDFE, 16'h0000);
        queue_request(OP_WR_BYTE, ADDR_LY, 16'h0000);
        queue_request(OP_RD_BYTE, ADDR_LY, 16'h0000);      // fixed value despite the write
        queue_request(OP_WR_BYTE, ADDR_SB, 16'h005A);
        queue_request(OP_WR_BYTE, ADDR_SC, {8'hFF, SC_START});
        queue_request(OP_WR_BYTE, ADDR_SC, 16'h0001);
        queue_request(OP_WR_WORD, ADDR_SB, {SC_START, 8'hA5}); // new byte goes out
        queue_request(OP_WR_WORD, 16'hFF80, 16'h1234);
        queue_request(OP_WR_BYTE, 16'hFFFE, 16'h0077);
        queue_request(OP_RD_WORD, 16'hFFFF, 16'h0000);     // wraps to address 0
        queue_request(OP_WR_BYTE, 16'hFFFF, 16'h00EE);     // unmapped, dropped
        queue_request(OP_RD_BYTE, 16'hFFFF, 16'h0000);
        queue_request(OP_SPARE_A, 16'($urandom), 16'($urandom));
        queue_request(OP_SPARE_B, 16'($urandom), 16'($urandom));
        queue_request(OP_WR_BYTE, ADDR_BOOT_OFF, 16'h0001); // overlay off
        queue_request(OP_RD_WORD, 16'h7FFF, 16'h0000);
        wait_drained();

        // Random passes with both overlay settings
        write_overlay_cfg(1'b0);
        queue_random(300);
        wait_drained();
        write_overlay_cfg(1'b1);
        queue_random(300);
        wait_drained();
        write_overlay_cfg(1'b0);
        queue_random(250);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("handheld_memory_map_decoder test passed");
        end else begin
            $display("handheld_memory_map_decoder test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/hmmd_pkg.sv
rtl/hmmd_ram.sv
rtl/hmmd_seq.sv
rtl/handheld_memory_map_decoder.sv
sim/handheld_memory_map_decoder_tb.sv
